>>> src/bbp_pkg.sv
// Shared constants and types for the basic-block partitioner.
// No dependencies; the datapath, controller, top level and bench refer to it by scoped names.
package bbp_pkg;

  localparam int INSN_DEPTH = 64;
  localparam int IDX_W      = $clog2(INSN_DEPTH);
  localparam int CNT_W      = $clog2(INSN_DEPTH + 1);
  localparam int RESULT_CAP = 64;
  localparam int ADDR_W     = 64;

  localparam logic [6:0] NO_BLOCK = 7'h7F;

  typedef struct packed {
    logic pad;
    logic tgt;
    logic fin;
    logic br;
    logic cjmp;
    logic ujmp;
    logic call;
    logic ret;
  } flag_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } tidx_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // input beat taken
    logic lead_init;  // final beat taken, start leader pass
    logic lchk;       // flags of insn i are on the read port
    logic scmp;       // address j is on the read port
    logic split;      // assign block ids
    logic eskip;      // insn i does not close a block
    logic ebr;        // capture result
    logic eacc;       // result beat taken
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ins_last;
    logic j_zero;
    logic jump_tgt;
    logic addr_match;
    logic blk_end;
    logic done;
  } sts_t;

endpackage

>>> src/bbp_ifs.sv
// Valid/ready channel interfaces for instruction beats and block beats.
// Depends on bbp_pkg for nothing but convention; widths are fixed.
interface bbp_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] insn_address;
  logic        is_return;
  logic        is_call_insn;
  logic        is_ujump;
  logic        is_cjump;
  logic        is_any_branch;
  logic        ends_flow;
  logic        has_target;
  logic [63:0] target_address;
  logic        last_insn;

  modport source(output valid, insn_address, is_return, is_call_insn, is_ujump,
                 is_cjump, is_any_branch, ends_flow, has_target, target_address,
                 last_insn, input ready);
  modport sink(input valid, insn_address, is_return, is_call_insn, is_ujump,
               is_cjump, is_any_branch, ends_flow, has_target, target_address,
               last_insn, output ready);
endinterface

interface bbp_out_if;
  logic              valid;
  logic              ready;
  logic [5:0]        block_id;
  logic [5:0]        start_index;
  logic [6:0]        end_index;
  logic signed [6:0] fallthrough_block;
  logic signed [6:0] branch_block;
  logic              last_block;

  modport source(output valid, block_id, start_index, end_index, fallthrough_block,
                 branch_block, last_block, input ready);
  modport sink(input valid, block_id, start_index, end_index, fallthrough_block,
               branch_block, last_block, output ready);
endinterface

>>> src/bbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbp_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/bbp_dp.sv
// Datapath: instruction stores, leader bits, counters and result register.
// Depends on bbp_pkg and bbp_ram.
module bbp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  bbp_pkg::cmd_t       cmd,
  output bbp_pkg::sts_t       sts,
  input  logic [63:0]         in_insn_address,
  input  logic                in_is_return,
  input  logic                in_is_call_insn,
  input  logic                in_is_ujump,
  input  logic                in_is_cjump,
  input  logic                in_is_any_branch,
  input  logic                in_ends_flow,
  input  logic                in_has_target,
  input  logic [63:0]         in_target_address,
  output logic [5:0]          out_block_id,
  output logic [5:0]          out_start_index,
  output logic [6:0]          out_end_index,
  output logic signed [6:0]   out_fallthrough_block,
  output logic signed [6:0]   out_branch_block,
  output logic                out_last_block
);
  localparam int IW = bbp_pkg::IDX_W;
  localparam int CW = bbp_pkg::CNT_W;

  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [bbp_pkg::INSN_DEPTH-1:0] lead_r, lead_nxt;
  logic [IW-1:0]                i_r, i_nxt, j_r, j_nxt, blk_r, blk_nxt, start_r, start_nxt;
  logic [63:0]                  tgt_r;

  logic [5:0]        id_r, st_r;
  logic [6:0]        end_r, fall_r, br_r;
  logic              last_r;

  logic [63:0]       addr_rd, tgt_rd;
  logic [$bits(bbp_pkg::flag_t)-1:0] flag_rd;
  logic [$bits(bbp_pkg::tidx_t)-1:0] tidx_rd;
  logic [IW-1:0]     bom_rd;
  bbp_pkg::flag_t    f, f_in;
  bbp_pkg::tidx_t    t, t_wr;
  logic              store_we, tidx_we, lead_adv;
  logic [IW-1:0]     blk_split, i_inc;
  logic              ins_last;

  assign f = bbp_pkg::flag_t'(flag_rd);
  assign t = bbp_pkg::tidx_t'(tidx_rd);

  always_comb begin
    f_in      = '0;
    f_in.ret  = in_is_return;
    f_in.call = in_is_call_insn;
    f_in.ujmp = in_is_ujump;
    f_in.cjmp = in_is_cjump;
    f_in.br   = in_is_any_branch;
    f_in.fin  = in_ends_flow;
    f_in.tgt  = in_has_target;
  end

  assign store_we = cmd.load && (cnt_r < CW'(bbp_pkg::INSN_DEPTH));
  assign ins_last = (CW'(i_r) + CW'(1)) == cnt_r;
  assign i_inc    = IW'(i_r + 1'b1);
  assign blk_split = blk_r + IW'((i_r != '0) && lead_r[i_r]);

  assign sts.ins_last   = ins_last;
  assign sts.j_zero     = (j_r == '0);
  assign sts.jump_tgt   = (f.ujmp || f.cjmp || f.call) && f.tgt;
  assign sts.addr_match = (addr_rd == tgt_r);
  assign sts.blk_end    = ins_last || lead_r[i_inc];
  assign sts.done       = last_r;

  assign lead_adv = (cmd.lchk && !sts.jump_tgt) ||
                    (cmd.scmp && (sts.addr_match || sts.j_zero));
  assign tidx_we  = lead_adv;
  always_comb begin
    t_wr       = '0;
    t_wr.found = cmd.scmp && sts.addr_match;
    t_wr.idx   = cmd.scmp ? j_r : '0;
  end

  bbp_ram #(.W(64), .D(bbp_pkg::INSN_DEPTH)) u_addr (
    .clk(clk), .we(store_we), .waddr(cnt_r[IW-1:0]), .wdata(in_insn_address),
    .raddr(j_r), .rdata(addr_rd));
  bbp_ram #(.W(64), .D(bbp_pkg::INSN_DEPTH)) u_tgt (
    .clk(clk), .we(store_we), .waddr(cnt_r[IW-1:0]), .wdata(in_target_address),
    .raddr(i_r), .rdata(tgt_rd));
  bbp_ram #(.W($bits(bbp_pkg::flag_t)), .D(bbp_pkg::INSN_DEPTH)) u_flag (
    .clk(clk), .we(store_we), .waddr(cnt_r[IW-1:0]), .wdata(f_in),
    .raddr(i_r), .rdata(flag_rd));
  bbp_ram #(.W($bits(bbp_pkg::tidx_t)), .D(bbp_pkg::INSN_DEPTH)) u_tidx (
    .clk(clk), .we(tidx_we), .waddr(i_r), .wdata(t_wr),
    .raddr(i_r), .rdata(tidx_rd));
  bbp_ram #(.W(IW), .D(bbp_pkg::INSN_DEPTH)) u_bom (
    .clk(clk), .we(cmd.split), .waddr(i_r), .wdata(blk_split),
    .raddr(t.idx), .rdata(bom_rd));

  always_comb begin
    cnt_nxt   = cnt_r;
    lead_nxt  = lead_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    blk_nxt   = blk_r;
    start_nxt = start_r;
    if (store_we) cnt_nxt = cnt_r + CW'(1);
    if (cmd.eacc && last_r) cnt_nxt = '0;
    if (cmd.lead_init) begin
      lead_nxt    = '0;
      lead_nxt[0] = 1'b1;
      i_nxt       = '0;
    end
    if (cmd.lchk) begin
      j_nxt = IW'(cnt_r - CW'(1));
      if ((f.br || f.fin) && !ins_last) lead_nxt[i_inc] = 1'b1;
    end
    if (cmd.scmp) begin
      if (sts.addr_match) lead_nxt[j_r] = 1'b1;
      else j_nxt = j_r - IW'(1);
    end
    if (lead_adv) begin
      i_nxt = ins_last ? '0 : i_inc;
      if (ins_last) blk_nxt = '0;
    end
    if (cmd.split) begin
      i_nxt     = ins_last ? '0 : i_inc;
      blk_nxt   = ins_last ? '0 : blk_split;
      start_nxt = '0;
    end
    if (cmd.eskip) i_nxt = i_inc;
    if (cmd.eacc) begin
      i_nxt     = i_inc;
      blk_nxt   = blk_r + IW'(1);
      start_nxt = i_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      lead_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      lead_r <= lead_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    blk_r   <= blk_nxt;
    start_r <= start_nxt;
    if (cmd.lchk) tgt_r <= tgt_rd;
  end

  // result capture: successor rules keyed on the block's last instruction
  always_ff @(posedge clk) begin
    if (cmd.ebr) begin
      id_r   <= 6'(blk_r);
      st_r   <= 6'(start_r);
      end_r  <= 7'(CW'(i_r) + CW'(1));
      last_r <= ins_last || (int'(blk_r) == bbp_pkg::RESULT_CAP - 1);
      fall_r <= bbp_pkg::NO_BLOCK;
      br_r   <= bbp_pkg::NO_BLOCK;
      priority if (f.ret) begin
      end else if (f.ujmp && f.tgt) begin
        br_r <= t.found ? 7'(bom_rd) : bbp_pkg::NO_BLOCK;
      end else if (f.cjmp && f.tgt) begin
        br_r   <= t.found ? 7'(bom_rd) : bbp_pkg::NO_BLOCK;
        fall_r <= ins_last ? bbp_pkg::NO_BLOCK : 7'(CW'(blk_r) + CW'(1));
      end else if (f.fin) begin
      end else begin
        fall_r <= ins_last ? bbp_pkg::NO_BLOCK : 7'(CW'(blk_r) + CW'(1));
      end
    end
  end

  assign out_block_id          = id_r;
  assign out_start_index       = st_r;
  assign out_end_index         = end_r;
  assign out_fallthrough_block = fall_r;
  assign out_branch_block      = br_r;
  assign out_last_block        = last_r;
endmodule

>>> src/bbp_ctrl.sv
// Controller: sequences load, leader search, block numbering and emission.
// Depends on bbp_pkg.
module bbp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last_insn,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bbp_pkg::sts_t sts,
  output bbp_pkg::cmd_t cmd
);
  typedef enum logic [10:0] {
    S_LOAD = 11'b00000000001,
    S_LRD  = 11'b00000000010,
    S_LCHK = 11'b00000000100,
    S_SRD  = 11'b00000001000,
    S_SCMP = 11'b00000010000,
    S_SPL  = 11'b00000100000,
    S_ERD  = 11'b00001000000,
    S_ECHK = 11'b00010000000,
    S_EBR  = 11'b00100000000,
    S_EOUT = 11'b01000000000,
    S_IDLE = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_acc, out_acc;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_EOUT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  always_comb begin
    cmd           = '0;
    cmd.load      = in_acc;
    cmd.lead_init = in_acc && in_last_insn;
    cmd.lchk      = (state_r == S_LCHK);
    cmd.scmp      = (state_r == S_SCMP);
    cmd.split     = (state_r == S_SPL);
    cmd.eskip     = (state_r == S_ECHK) && !sts.blk_end;
    cmd.ebr       = (state_r == S_EBR);
    cmd.eacc      = out_acc;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: if (in_acc && in_last_insn) state_nxt = S_LRD;
      S_LRD:  state_nxt = S_LCHK;
      S_LCHK: begin
        if (sts.jump_tgt) state_nxt = S_SRD;
        else state_nxt = sts.ins_last ? S_SPL : S_LRD;
      end
      S_SRD:  state_nxt = S_SCMP;
      S_SCMP: begin
        if (sts.addr_match || sts.j_zero) state_nxt = sts.ins_last ? S_SPL : S_LRD;
        else state_nxt = S_SRD;
      end
      S_SPL:  if (sts.ins_last) state_nxt = S_ERD;
      S_ERD:  state_nxt = S_ECHK;
      S_ECHK: state_nxt = sts.blk_end ? S_EBR : S_ERD;
      S_EBR:  state_nxt = S_EOUT;
      S_EOUT: if (out_acc) state_nxt = sts.done ? S_LOAD : S_ERD;
      S_IDLE: state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

>>> src/basic_block_partitioner.sv
// Basic-block partitioner: loads instruction beats, then emits one beat per block.
// Load: one instruction beat per cycle. After the final beat, the leader pass checks each
//   stored instruction and searches stored addresses newest first for each targeted
//   branch's target; numbering assigns block ids; each block beat is held until taken.
// Reset (synchronous, rst_n low) clears the count, leader bits and controller; the stores
//   are not cleared and input is taken once the controller passes from S_IDLE to S_LOAD.
module basic_block_partitioner (
  input logic clk,
  input logic rst_n,
  bbp_in_if.sink    in_if,
  bbp_out_if.source out_if
);
  bbp_pkg::cmd_t cmd;
  bbp_pkg::sts_t sts;

  // controller owns both handshakes; datapath only sees commands
  bbp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_last_insn (in_if.last_insn),
    .in_ready     (in_if.ready),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // stores, leader bits, block numbering and the result register
  bbp_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_insn_address       (in_if.insn_address),
    .in_is_return          (in_if.is_return),
    .in_is_call_insn       (in_if.is_call_insn),
    .in_is_ujump           (in_if.is_ujump),
    .in_is_cjump           (in_if.is_cjump),
    .in_is_any_branch      (in_if.is_any_branch),
    .in_ends_flow          (in_if.ends_flow),
    .in_has_target         (in_if.has_target),
    .in_target_address     (in_if.target_address),
    .out_block_id          (out_if.block_id),
    .out_start_index       (out_if.start_index),
    .out_end_index         (out_if.end_index),
    .out_fallthrough_block (out_if.fallthrough_block),
    .out_branch_block      (out_if.branch_block),
    .out_last_block        (out_if.last_block)
  );

`ifndef SYNTHESIS
  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_if.ready && out_if.valid))
    else $error("input taken while a block beat is pending");

  // final instruction beat ends loading
  a_last_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && in_if.last_insn) |=> !in_if.ready)
    else $error("still loading after final instruction");

  // final block beat returns to loading
  a_last_block_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.ready && out_if.last_block) |=> in_if.ready)
    else $error("not loading after final block beat");
`endif
endmodule

>>> bench/bbp_tb_ifs.sv
`timescale 1ns / 100ps
// Testbench-side note: the channel interfaces live with the RTL (bbp_ifs.sv).
// This file holds the beat record types the bench queues; no dependencies.
package bbp_tb_pkg;
  typedef struct packed {
    logic [63:0] addr;
    logic        ret, call, ujmp, cjmp, br, fin, tgt;
    logic [63:0] target;
    logic        last;
  } insn_beat_t;

  typedef struct packed {
    logic [5:0]        id;
    logic [5:0]        first;
    logic [6:0]        stop;
    logic signed [6:0] fall;
    logic signed [6:0] jump;
    logic              tail;
  } block_beat_t;
endpackage

>>> bench/tb.sv
`timescale 1ns / 100ps
// Top-level bench for basic_block_partitioner: random functions, block predictor,
// scoreboard. Depends on bbp_pkg, bbp_ifs (RTL) and bbp_tb_pkg.
module tb;
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bbp_in_if  in_ch();
  bbp_out_if out_ch();

  basic_block_partitioner dut (.clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch));

  initial begin
    forever #4 clk = ~clk;
  end

  // Stimulus store and expected block beats.
  bbp_tb_pkg::insn_beat_t  pending_insns[$];
  bbp_tb_pkg::block_beat_t expected_blocks[$];
  int errors = 0;
  int beats_sent = 0;
  int blocks_seen = 0;
  int funcs_sent = 0;
  int total_beats = 0;
  bit stim_done = 0;

  // Predictor state: mirror of the stores.
  logic [63:0] p_addr[bbp_pkg::INSN_DEPTH];
  logic [63:0] p_tgt[bbp_pkg::INSN_DEPTH];
  logic [6:0]  p_flag[bbp_pkg::INSN_DEPTH];  // {tgt,fin,br,cjmp,ujmp,call,ret}
  int          p_count = 0;

  function automatic int latest_match(logic [63:0] a);
    for (int i = p_count - 1; i >= 0; i--) begin
      if (p_addr[i] == a) return i;
    end
    return -1;
  endfunction

  // Absorb one accepted beat; on the final beat, predict every block beat.
  task automatic predict_blocks(bbp_tb_pkg::insn_beat_t b);
    bit lead[bbp_pkg::INSN_DEPTH];
    int blk_of[bbp_pkg::INSN_DEPTH];
    int starts[bbp_pkg::INSN_DEPTH];
    int ends[bbp_pkg::INSN_DEPTH];
    int nblk, i, s, t, e, li, nxt, fall, jmp;
    logic [6:0] f;
    bbp_tb_pkg::block_beat_t r;
    if (p_count < bbp_pkg::INSN_DEPTH) begin
      p_addr[p_count] = b.addr;
      p_tgt[p_count] = b.target;
      p_flag[p_count] = {b.tgt, b.fin, b.br, b.cjmp, b.ujmp, b.call, b.ret};
      p_count++;
    end
    if (!b.last || p_count == 0) return;
    foreach (lead[k]) lead[k] = 0;
    lead[0] = 1;
    for (i = 0; i < p_count; i++) begin
      f = p_flag[i];
      if ((f[4] || f[5]) && i + 1 < p_count) lead[i + 1] = 1;
      if ((f[1] || f[2] || f[3]) && f[6]) begin
        t = latest_match(p_tgt[i]);
        if (t >= 0) lead[t] = 1;
      end
    end
    nblk = 0;
    i = 0;
    while (i < p_count) begin
      s = i;
      i++;
      while (i < p_count && !lead[i]) i++;
      starts[nblk] = s;
      ends[nblk] = i;
      for (int k = s; k < i; k++) blk_of[k] = nblk;
      nblk++;
    end
    if (nblk > bbp_pkg::RESULT_CAP) nblk = bbp_pkg::RESULT_CAP;
    for (int k = 0; k < nblk; k++) begin
      e = ends[k];
      li = e - 1;
      f = p_flag[li];
      nxt = (e < p_count) ? blk_of[e] : -1;
      fall = -1;
      jmp = -1;
      if (f[0]) begin
        // return: no successors
      end else if (f[2] && f[6]) begin
        t = latest_match(p_tgt[li]);
        jmp = (t >= 0) ? blk_of[t] : -1;
      end else if (f[3] && f[6]) begin
        t = latest_match(p_tgt[li]);
        jmp = (t >= 0) ? blk_of[t] : -1;
        fall = nxt;
      end else if (!f[5]) begin
        fall = nxt;
      end
      r.id = k[5:0];
      r.first = starts[k][5:0];
      r.stop = e[6:0];
      r.fall = fall[6:0];
      r.jump = jmp[6:0];
      r.tail = (k + 1 == nblk);
      expected_blocks.insert(expected_blocks.size(), r);
    end
    p_count = 0;
  endtask

  task automatic report(string what, int got, int want);
    $display("tb: mismatch on %s: got %0d, want %0d (block beat %0d)",
             what, got, want, blocks_seen);
    errors++;
  endtask

  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: hold the beat until accepted, random gaps between beats.
  int in_gap = 0;
  bbp_tb_pkg::insn_beat_t cur;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_blocks(cur);
        beats_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0 || pending_insns.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_ch.valid <= 1'b0;
        end else begin
          cur = pending_insns.pop_front();
          in_gap = gap_len();
          in_ch.valid <= 1'b1;
          in_ch.insn_address <= cur.addr;
          in_ch.is_return <= cur.ret;
          in_ch.is_call_insn <= cur.call;
          in_ch.is_ujump <= cur.ujmp;
          in_ch.is_cjump <= cur.cjmp;
          in_ch.is_any_branch <= cur.br;
          in_ch.ends_flow <= cur.fin;
          in_ch.has_target <= cur.tgt;
          in_ch.target_address <= cur.target;
          in_ch.last_insn <= cur.last;
        end
      end
    end
  end

  // Monitor: random backpressure, field-by-field check against oldest beat.
  int out_stall = 0;
  always @(posedge clk) begin
    bbp_tb_pkg::block_beat_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_blocks.size() == 0) begin
          report("unexpected block beat, block_id", out_ch.block_id, -1);
        end else begin
          want = expected_blocks.pop_front();
          if (out_ch.block_id != want.id) report("block_id", out_ch.block_id, want.id);
          if (out_ch.start_index != want.first)
            report("start_index", out_ch.start_index, want.first);
          if (out_ch.end_index != want.stop) report("end_index", out_ch.end_index, want.stop);
          if (out_ch.fallthrough_block != want.fall)
            report("fallthrough_block", out_ch.fallthrough_block, want.fall);
          if (out_ch.branch_block != want.jump)
            report("branch_block", out_ch.branch_block, want.jump);
          if (out_ch.last_block != want.tail)
            report("last_block", out_ch.last_block, want.tail);
        end
        blocks_seen++;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_stall = gap_len();
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Build one function of n instructions; unless rand_addr is set, addresses come from a small
  // pool so targets often land on stored instructions (and duplicates occur).
  task automatic queue_function(int n, bit rand_addr);
    bbp_tb_pkg::insn_beat_t b;
    logic [63:0] base;
    int kind;
    base = {$urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      b = '0;
      b.addr = rand_addr ? {$urandom, $urandom} : base + 64'($urandom_range(0, n + 2) * 4);
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin b.ret = 1; b.br = 1; b.fin = 1; end
        1: begin b.call = 1; b.br = 1; end
        2: begin b.ujmp = 1; b.br = 1; b.fin = 1; end
        3, 4: begin b.cjmp = 1; b.br = 1; end
        5: b = bbp_tb_pkg::insn_beat_t'({$urandom, $urandom, $urandom, $urandom,
                                          8'($urandom)});
        default: ;
      endcase
      b.addr = (kind == 5) ? b.addr : b.addr;
      if (kind != 5) begin
        b.tgt = (b.call || b.ujmp || b.cjmp) ? ($urandom_range(0, 5) != 0)
                                              : 1'($urandom_range(0, 1));
        b.target = ($urandom_range(0, 4) != 0) ? base + 64'($urandom_range(0, n + 2) * 4)
                                                : {$urandom, $urandom};
      end
      b.last = (i == n - 1);
      pending_insns.insert(pending_insns.size(), b);
    end
    funcs_sent++;
  endtask

  task automatic queue_one(logic [63:0] a, logic [6:0] f, logic [63:0] t, bit last);
    bbp_tb_pkg::insn_beat_t b;
    b.addr = a;
    {b.tgt, b.fin, b.br, b.cjmp, b.ujmp, b.call, b.ret} = f;
    b.target = t;
    b.last = last;
    pending_insns.insert(pending_insns.size(), b);
  endtask

  int watchdog;
  int pick;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.insn_address = '0;
    in_ch.is_return = 1'b0;
    in_ch.is_call_insn = 1'b0;
    in_ch.is_ujump = 1'b0;
    in_ch.is_cjump = 1'b0;
    in_ch.is_any_branch = 1'b0;
    in_ch.ends_flow = 1'b0;
    in_ch.has_target = 1'b0;
    in_ch.target_address = '0;
    in_ch.last_insn = 1'b0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single insn; extreme addresses; each branch kind; backward
    // target; target not found; duplicate addresses (latest wins).
    queue_one('0, 7'b0000000, '0, 1'b1);
    queue_one('1, 7'b1000100, '1, 1'b0);              // ujmp to itself
    queue_one(64'h10, 7'b1001000, 64'h20, 1'b0);      // cjmp forward
    queue_one(64'h20, 7'b1000010, 64'h10, 1'b0);      // call back
    queue_one(64'h20, 7'b1000000, '1, 1'b0);          // duplicate address
    queue_one(64'h30, 7'b1001000, 64'hdead, 1'b0);    // target not stored
    queue_one(64'h34, 7'b0100000, '0, 1'b0);          // plain flow end
    queue_one(64'h38, 7'b0010000, '0, 1'b0);          // branch without kind
    queue_one(64'h3c, 7'b1000101, 64'h10, 1'b0);      // ret with ujmp flags
    queue_one(64'h40, 7'b1111111, 64'h38, 1'b0);      // all flags
    queue_one(64'h44, 7'b0000000, '0, 1'b1);
    queue_one(64'h0, 7'b0010001, '0, 1'b1);           // lone return
    funcs_sent += 3;
    // Over capacity: every insn ends a block, 70 beats, 64 stored.
    for (int i = 0; i < 70; i++) queue_one(64'(i), 7'b0110000, '0, i == 69);
    funcs_sent++;

    // Random functions, mostly small, a few at full size.
    while (pending_insns.size() < 250) begin
      pick = $urandom_range(0, 19);
      queue_function(pick == 0 ? 64 : $urandom_range(1, 12), pick == 1);
    end
    queue_function(64, 1);
    total_beats = pending_insns.size();
    wait (beats_sent == total_beats);
    stim_done = 1;
    watchdog = 0;
    while (expected_blocks.size() != 0 && watchdog < 100000) begin
      @(posedge clk);
      watchdog++;
    end
    repeat (200) @(posedge clk);
    $display("tb: %0d instruction beats in %0d functions, %0d block beats checked",
             beats_sent, funcs_sent, blocks_seen);
    if (errors == 0 && expected_blocks.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: %0d mismatches, %0d block beats never seen", errors,
               expected_blocks.size());
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: timeout");
    $display("tb: done, errors");
    $finish;
  end
endmodule

>>> filelist.f
src/bbp_pkg.sv
src/bbp_ifs.sv
src/bbp_ram.sv
src/bbp_dp.sv
src/bbp_ctrl.sv
src/basic_block_partitioner.sv
bench/bbp_tb_ifs.sv
bench/tb.sv
